[hw/rtl/stt_pkg.sv]
`timescale 1ns / 1ps

package stt_pkg;

    localparam int OFFSET_WIDTH    = 24;
    localparam int LINE_WIDTH      = 16;
    localparam int LENGTH_WIDTH    = 16;
    localparam int KEYWORD_COUNT   = 18;
    localparam int MAX_KEYWORD_LEN = 10;
    localparam int KIND_WIDTH      = 6;
    localparam int KW_POS_WIDTH    = $clog2(MAX_KEYWORD_LEN);

    // Lexer modes
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_IDENT  = 3'd1;
    localparam logic [2:0] MODE_NUMBER = 3'd2;
    localparam logic [2:0] MODE_OPWAIT = 3'd3;
    localparam logic [2:0] MODE_DONE   = 3'd4;

    // Token kinds
    localparam logic [KIND_WIDTH-1:0] TK_EOF     = 6'd0;
    localparam logic [KIND_WIDTH-1:0] TK_ILLEGAL = 6'd1;
    localparam logic [KIND_WIDTH-1:0] TK_IDENT   = 6'd2;
    localparam logic [KIND_WIDTH-1:0] TK_INT     = 6'd3;
    localparam logic [KIND_WIDTH-1:0] TK_FLOAT   = 6'd4;
    localparam logic [KIND_WIDTH-1:0] TK_ASSIGN  = 6'd5;
    localparam logic [KIND_WIDTH-1:0] TK_EQ      = 6'd6;
    localparam logic [KIND_WIDTH-1:0] TK_SEMI    = 6'd7;
    localparam logic [KIND_WIDTH-1:0] TK_LPAREN  = 6'd8;
    localparam logic [KIND_WIDTH-1:0] TK_RPAREN  = 6'd9;
    localparam logic [KIND_WIDTH-1:0] TK_LBRACE  = 6'd10;
    localparam logic [KIND_WIDTH-1:0] TK_RBRACE  = 6'd11;
    localparam logic [KIND_WIDTH-1:0] TK_LBRACK  = 6'd12;
    localparam logic [KIND_WIDTH-1:0] TK_RBRACK  = 6'd13;
    localparam logic [KIND_WIDTH-1:0] TK_COMMA   = 6'd14;
    localparam logic [KIND_WIDTH-1:0] TK_PLUS    = 6'd15;
    localparam logic [KIND_WIDTH-1:0] TK_LT      = 6'd16;
    localparam logic [KIND_WIDTH-1:0] TK_LE      = 6'd17;
    localparam logic [KIND_WIDTH-1:0] TK_GT      = 6'd18;
    localparam logic [KIND_WIDTH-1:0] TK_GE      = 6'd19;
    localparam logic [KIND_WIDTH-1:0] TK_NOT     = 6'd20;
    localparam logic [KIND_WIDTH-1:0] TK_NE      = 6'd21;
    localparam logic [KIND_WIDTH-1:0] TK_STAR    = 6'd22;
    localparam logic [KIND_WIDTH-1:0] TK_SLASH   = 6'd23;
    localparam logic [KIND_WIDTH-1:0] TK_MINUS   = 6'd24;

    // Pending operator codes
    localparam logic [1:0] OP_ASSIGN = 2'd0;
    localparam logic [1:0] OP_LT     = 2'd1;
    localparam logic [1:0] OP_GT     = 2'd2;
    localparam logic [1:0] OP_NOT    = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_EQUAL = 8'h3D;

    localparam logic [127:0] KW_TEXT [KEYWORD_COUNT] = '{
        "function", "define", "return", "let", "henceforth", "int", "float",
        "byte", "bool", "void", "string", "if", "else", "while", "for",
        "true", "false", "entry"
    };
    localparam logic [4:0] KW_LEN [KEYWORD_COUNT] = '{
        5'd8, 5'd6, 5'd6, 5'd3, 5'd10, 5'd3, 5'd5, 5'd4, 5'd4, 5'd4,
        5'd6, 5'd2, 5'd4, 5'd5, 5'd3, 5'd4, 5'd5, 5'd5
    };
    localparam logic [KIND_WIDTH-1:0] KW_KIND [KEYWORD_COUNT] = '{
        6'd25, 6'd25, 6'd26, 6'd27, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31,
        6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40
    };

    typedef struct packed {
        logic [KIND_WIDTH-1:0]   kind;
        logic [OFFSET_WIDTH-1:0] start;
        logic [LENGTH_WIDTH-1:0] len;
        logic [LINE_WIDTH-1:0]   line;
        logic                    last;
    } t_token;

    // Character of keyword k at position pos, or zero past its end.
    function automatic logic [7:0] kw_char(input int k, input logic [KW_POS_WIDTH-1:0] pos);
        logic [7:0] ch;
        int         sh;
        ch = CH_NUL;
        sh = 0;
        if (int'(pos) < int'(KW_LEN[k])) begin
            sh = 8 * (int'(KW_LEN[k]) - 1 - int'(pos));
            ch = KW_TEXT[k][sh +: 8];
        end
        return ch;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [KIND_WIDTH-1:0] op_single(input logic [1:0] op);
        logic [KIND_WIDTH-1:0] k;
        case (op)
            OP_ASSIGN: k = TK_ASSIGN;
            OP_LT:     k = TK_LT;
            OP_GT:     k = TK_GT;
            default:   k = TK_NOT;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_WIDTH-1:0] op_double(input logic [1:0] op);
        logic [KIND_WIDTH-1:0] k;
        case (op)
            OP_ASSIGN: k = TK_EQ;
            OP_LT:     k = TK_LE;
            OP_GT:     k = TK_GE;
            default:   k = TK_NE;
        endcase
        return k;
    endfunction

endpackage

[hw/rtl/source_text_tokenizer_core.sv]
`timescale 1ns / 1ps

// Channel   Valid        Ready        Payload
// input     i_in_valid   o_in_ready   i_char_in, i_is_end
// output    o_out_valid  i_out_ready  o_token_kind, o_start_offset, o_token_length,
//                                     o_line_number, o_last_of_run
//
// One character per cycle while the result queue has room: a character is
// captured in an input register and lexed from there, when its zero, one or
// two tokens enter a four-entry result queue. Lexing waits only while the
// queue has fewer than two free entries; the tokens are registered in the
// queue and presented from its head.
// Synchronous active-low reset clears lexer state and empties the queue.

module source_text_tokenizer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [7:0]                          i_char_in,
    input  logic                                i_is_end,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [stt_pkg::KIND_WIDTH-1:0]      o_token_kind,
    output logic [stt_pkg::OFFSET_WIDTH-1:0]    o_start_offset,
    output logic [stt_pkg::LENGTH_WIDTH-1:0]    o_token_length,
    output logic [stt_pkg::LINE_WIDTH-1:0]      o_line_number,
    output logic                                o_last_of_run
);
    import stt_pkg::*;

    localparam logic [OFFSET_WIDTH-1:0]  OFS_MAX = '1;
    localparam logic [LENGTH_WIDTH-1:0]  LEN_MAX = '1;
    localparam logic [LINE_WIDTH-1:0]    LINE_MAX = '1;
    localparam logic [LENGTH_WIDTH-1:0]  LEN_ONE = LENGTH_WIDTH'(1);
    localparam logic [LENGTH_WIDTH-1:0]  LEN_TWO = LENGTH_WIDTH'(2);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_end;

    // Lexer state
    logic [2:0]               r_mode, n_mode;
    logic [1:0]               r_pend, n_pend;
    logic [OFFSET_WIDTH-1:0]  r_tstart, n_tstart;
    logic [LENGTH_WIDTH-1:0]  r_tlen, n_tlen;
    logic                     r_seen_dot, n_seen_dot;
    logic                     r_bad, n_bad;
    logic [KEYWORD_COUNT-1:0] r_kw_alive, n_kw_alive;
    logic [OFFSET_WIDTH-1:0]  r_offset, n_offset;
    logic [LINE_WIDTH-1:0]    r_line, n_line;

    // Result queue
    t_token     r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    logic       fire;
    logic       pop;
    logic [1:0] emit_n;
    t_token     tok0, tok1;

    // Closing of the open token
    logic   cls_valid;
    t_token cls_tok;
    // Start of a new token from the current character
    logic       f_emit;
    logic [KIND_WIDTH-1:0] f_kind;
    logic       f_letter, f_digit, f_op;
    logic [1:0] f_pend;
    logic       f_newline;
    t_token     f_tok, eof_tok, dbl_tok;

    logic [KIND_WIDTH-1:0]    id_kind;
    logic [KEYWORD_COUNT-1:0] kw_first, kw_next;
    logic                     c_is_word, c_is_num;

    assign fire        = r_in_valid && (r_cnt <= 3'd2);
    assign o_in_ready  = !r_in_valid || fire;
    assign pop         = o_out_valid && i_out_ready;
    assign o_out_valid = (r_cnt != 3'd0);

    assign o_token_kind   = r_q[r_rp].kind;
    assign o_start_offset = r_q[r_rp].start;
    assign o_token_length = r_q[r_rp].len;
    assign o_line_number  = r_q[r_rp].line;
    assign o_last_of_run  = r_q[r_rp].last;

    assign c_is_word = is_letter(r_char) || is_digit(r_char) || (r_char == CH_UNDER);
    assign c_is_num  = is_digit(r_char) || (r_char == CH_DOT);

    // Keyword tracking: one compare per keyword against the next character.
    always_comb begin
        for (int k = 0; k < KEYWORD_COUNT; k++) begin
            kw_first[k] = (kw_char(k, '0) == r_char);
            kw_next[k]  = r_kw_alive[k] && (r_tlen < LENGTH_WIDTH'(MAX_KEYWORD_LEN))
                          && (kw_char(k, r_tlen[KW_POS_WIDTH-1:0]) == r_char);
        end
    end

    // The lowest-numbered live keyword of matching length names the kind.
    always_comb begin
        id_kind = TK_IDENT;
        for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
            if (r_kw_alive[k] && (r_tlen == LENGTH_WIDTH'(KW_LEN[k]))) begin
                id_kind = KW_KIND[k];
            end
        end
    end

    always_comb begin
        cls_valid   = 1'b1;
        cls_tok     = '0;
        cls_tok.start = r_tstart;
        cls_tok.len   = r_tlen;
        cls_tok.line  = r_line;
        case (r_mode)
            MODE_IDENT:  cls_tok.kind = id_kind;
            MODE_NUMBER: cls_tok.kind = r_bad ? TK_ILLEGAL : (r_seen_dot ? TK_FLOAT : TK_INT);
            MODE_OPWAIT: begin
                cls_tok.kind = op_single(r_pend);
                cls_tok.len  = LEN_ONE;
            end
            default:     cls_valid = 1'b0;
        endcase

        eof_tok       = '0;
        eof_tok.kind  = TK_EOF;
        eof_tok.start = r_offset;
        eof_tok.line  = r_line;

        dbl_tok       = '0;
        dbl_tok.kind  = op_double(r_pend);
        dbl_tok.start = r_tstart;
        dbl_tok.len   = LEN_TWO;
        dbl_tok.line  = r_line;
    end

    always_comb begin
        f_emit    = 1'b1;
        f_kind    = TK_ILLEGAL;
        f_letter  = 1'b0;
        f_digit   = 1'b0;
        f_op      = 1'b0;
        f_pend    = OP_ASSIGN;
        f_newline = 1'b0;
        case (r_char)
            CH_SPACE, CH_TAB, CH_CR: f_emit = 1'b0;
            CH_LF: begin
                f_emit    = 1'b0;
                f_newline = 1'b1;
            end
            8'h3D: begin f_emit = 1'b0; f_op = 1'b1; f_pend = OP_ASSIGN; end
            8'h3C: begin f_emit = 1'b0; f_op = 1'b1; f_pend = OP_LT;     end
            8'h3E: begin f_emit = 1'b0; f_op = 1'b1; f_pend = OP_GT;     end
            8'h21: begin f_emit = 1'b0; f_op = 1'b1; f_pend = OP_NOT;    end
            8'h3B: f_kind = TK_SEMI;
            8'h28: f_kind = TK_LPAREN;
            8'h29: f_kind = TK_RPAREN;
            8'h7B: f_kind = TK_LBRACE;
            8'h7D: f_kind = TK_RBRACE;
            8'h5B: f_kind = TK_LBRACK;
            8'h5D: f_kind = TK_RBRACK;
            8'h2C: f_kind = TK_COMMA;
            8'h2B: f_kind = TK_PLUS;
            8'h2A: f_kind = TK_STAR;
            8'h2F: f_kind = TK_SLASH;
            8'h2D: f_kind = TK_MINUS;
            default: begin
                if (is_letter(r_char)) begin
                    f_emit   = 1'b0;
                    f_letter = 1'b1;
                end else if (is_digit(r_char)) begin
                    f_emit  = 1'b0;
                    f_digit = 1'b1;
                end
            end
        endcase
        f_tok       = '0;
        f_tok.kind  = f_kind;
        f_tok.start = r_offset;
        f_tok.len   = LEN_ONE;
        f_tok.line  = r_line;
    end

    // Main lexing step for the registered character.
    always_comb begin
        n_mode     = r_mode;
        n_pend     = r_pend;
        n_tstart   = r_tstart;
        n_tlen     = r_tlen;
        n_seen_dot = r_seen_dot;
        n_bad      = r_bad;
        n_kw_alive = r_kw_alive;
        n_offset   = r_offset;
        n_line     = r_line;
        emit_n     = 2'd0;
        tok0       = cls_tok;
        tok1       = eof_tok;

        if (r_mode != MODE_DONE) begin
            if (r_end || (r_char == CH_NUL)) begin
                n_mode = MODE_DONE;
                if (cls_valid) begin
                    emit_n = 2'd2;
                end else begin
                    tok0   = eof_tok;
                    emit_n = 2'd1;
                end
            end else if ((r_mode == MODE_OPWAIT) && (r_char == CH_EQUAL)) begin
                tok0   = dbl_tok;
                emit_n = 2'd1;
                n_mode = MODE_IDLE;
            end else if ((r_mode == MODE_IDENT) && c_is_word) begin
                n_kw_alive = kw_next;
                if (r_tlen != LEN_MAX) begin
                    n_tlen = r_tlen + LEN_ONE;
                end
            end else if ((r_mode == MODE_NUMBER) && c_is_num) begin
                if (r_char == CH_DOT) begin
                    if (r_seen_dot) begin
                        n_bad = 1'b1;
                    end
                    n_seen_dot = 1'b1;
                end
                if (r_tlen != LEN_MAX) begin
                    n_tlen = r_tlen + LEN_ONE;
                end
            end else begin
                // The open token closes and this character starts afresh.
                n_mode   = MODE_IDLE;
                n_tstart = r_offset;
                if (f_newline && (r_line != LINE_MAX)) begin
                    n_line = r_line + LINE_WIDTH'(1);
                end
                if (f_op) begin
                    n_mode = MODE_OPWAIT;
                    n_pend = f_pend;
                end
                if (f_letter) begin
                    n_mode     = MODE_IDENT;
                    n_kw_alive = kw_first;
                    n_tlen     = LEN_ONE;
                end
                if (f_digit) begin
                    n_mode     = MODE_NUMBER;
                    n_seen_dot = 1'b0;
                    n_bad      = 1'b0;
                    n_tlen     = LEN_ONE;
                end
                if (cls_valid && f_emit) begin
                    tok1   = f_tok;
                    emit_n = 2'd2;
                end else if (cls_valid) begin
                    emit_n = 2'd1;
                end else if (f_emit) begin
                    tok0   = f_tok;
                    emit_n = 2'd1;
                end
            end
            if (r_offset != OFS_MAX) begin
                n_offset = r_offset + OFFSET_WIDTH'(1);
            end
        end

        tok0.last = (emit_n == 2'd1);
        tok1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_char <= i_char_in;
            r_end  <= i_is_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_pend     <= OP_ASSIGN;
            r_tstart   <= '0;
            r_tlen     <= '0;
            r_seen_dot <= 1'b0;
            r_bad      <= 1'b0;
            r_kw_alive <= '0;
            r_offset   <= '0;
            r_line     <= LINE_WIDTH'(1);
        end else if (fire) begin
            r_mode     <= n_mode;
            r_pend     <= n_pend;
            r_tstart   <= n_tstart;
            r_tlen     <= n_tlen;
            r_seen_dot <= n_seen_dot;
            r_bad      <= n_bad;
            r_kw_alive <= n_kw_alive;
            r_offset   <= n_offset;
            r_line     <= n_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && (emit_n != 2'd0)) begin
            r_q[r_wp] <= tok0;
        end
        if (fire && (emit_n == 2'd2)) begin
            r_q[r_wp + 2'd1] <= tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (fire) begin
                r_wp <= r_wp + emit_n;
            end
            if (pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + (fire ? {1'b0, emit_n} : 3'd0) - (pop ? 3'd1 : 3'd0);
        end
    end

endmodule

[dv/source_text_tokenizer_checker.sv]
`timescale 1ns / 1ps

module source_text_tokenizer_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [7:0]                       i_char_in,
    input  logic                             i_is_end,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [stt_pkg::KIND_WIDTH-1:0]   i_token_kind,
    input  logic [stt_pkg::OFFSET_WIDTH-1:0] i_start_offset,
    input  logic [stt_pkg::LENGTH_WIDTH-1:0] i_token_length,
    input  logic [stt_pkg::LINE_WIDTH-1:0]   i_line_number,
    input  logic                             i_last_of_run,
    output int                               o_pending,
    output int                               o_fail_count
);
    import stt_pkg::*;

    localparam logic [KIND_WIDTH-1:0] TK_KW_FUNCTION = 6'd25;
    localparam logic [KIND_WIDTH-1:0] TK_KW_RETURN   = 6'd26;
    localparam logic [KIND_WIDTH-1:0] TK_KW_LET      = 6'd27;
    localparam logic [KIND_WIDTH-1:0] TK_KW_INT      = 6'd28;
    localparam logic [KIND_WIDTH-1:0] TK_KW_FLOAT    = 6'd29;
    localparam logic [KIND_WIDTH-1:0] TK_KW_BYTE     = 6'd30;
    localparam logic [KIND_WIDTH-1:0] TK_KW_BOOL     = 6'd31;
    localparam logic [KIND_WIDTH-1:0] TK_KW_VOID     = 6'd32;
    localparam logic [KIND_WIDTH-1:0] TK_KW_STRING   = 6'd33;
    localparam logic [KIND_WIDTH-1:0] TK_KW_IF       = 6'd34;
    localparam logic [KIND_WIDTH-1:0] TK_KW_ELSE     = 6'd35;
    localparam logic [KIND_WIDTH-1:0] TK_KW_WHILE    = 6'd36;
    localparam logic [KIND_WIDTH-1:0] TK_KW_FOR      = 6'd37;
    localparam logic [KIND_WIDTH-1:0] TK_KW_TRUE     = 6'd38;
    localparam logic [KIND_WIDTH-1:0] TK_KW_FALSE    = 6'd39;
    localparam logic [KIND_WIDTH-1:0] TK_KW_ENTRY    = 6'd40;

    localparam logic [LENGTH_WIDTH-1:0] LEN_ONE = LENGTH_WIDTH'(1);
    localparam logic [LENGTH_WIDTH-1:0] LEN_TWO = LENGTH_WIDTH'(2);

    typedef enum logic [2:0] {LEX_IDLE, LEX_WORD, LEX_NUM, LEX_OP, LEX_DONE} t_lex_mode;

    t_lex_mode                 lex_mode;
    logic [1:0]                op_held;
    logic [OFFSET_WIDTH-1:0]   tok_start;
    logic [OFFSET_WIDTH-1:0]   byte_pos;
    logic [LENGTH_WIDTH-1:0]   tok_len;
    logic [LINE_WIDTH-1:0]     line_no;
    logic                      dot_seen;
    logic                      num_bad;
    logic [KEYWORD_COUNT-1:0]  kw_live;
    t_token                    expected_tokens[$];
    t_token                    want;
    int                        fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic void keyword_at(input int k, output string word,
                                       output logic [KIND_WIDTH-1:0] kind);
        case (k)
            0:       begin word = "function";   kind = TK_KW_FUNCTION; end
            1:       begin word = "define";     kind = TK_KW_FUNCTION; end
            2:       begin word = "return";     kind = TK_KW_RETURN;   end
            3:       begin word = "let";        kind = TK_KW_LET;      end
            4:       begin word = "henceforth"; kind = TK_KW_LET;      end
            5:       begin word = "int";        kind = TK_KW_INT;      end
            6:       begin word = "float";      kind = TK_KW_FLOAT;    end
            7:       begin word = "byte";       kind = TK_KW_BYTE;     end
            8:       begin word = "bool";       kind = TK_KW_BOOL;     end
            9:       begin word = "void";       kind = TK_KW_VOID;     end
            10:      begin word = "string";     kind = TK_KW_STRING;   end
            11:      begin word = "if";         kind = TK_KW_IF;       end
            12:      begin word = "else";       kind = TK_KW_ELSE;     end
            13:      begin word = "while";      kind = TK_KW_WHILE;    end
            14:      begin word = "for";        kind = TK_KW_FOR;      end
            15:      begin word = "true";       kind = TK_KW_TRUE;     end
            16:      begin word = "false";      kind = TK_KW_FALSE;    end
            default: begin word = "entry";      kind = TK_KW_ENTRY;    end
        endcase
    endfunction

    function automatic logic letter_byte(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic digit_byte(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void push_token(input logic [KIND_WIDTH-1:0] kind,
                                       input logic [OFFSET_WIDTH-1:0] start,
                                       input logic [LENGTH_WIDTH-1:0] len);
        t_token t;
        t.kind  = kind;
        t.start = start;
        t.len   = len;
        t.line  = line_no;
        t.last  = 1'b0;
        expected_tokens = {expected_tokens, t};
    endfunction

    // A keyword stays live only while every byte so far matches its spelling.
    function automatic void narrow_keywords(input logic [7:0] c,
                                            input logic [LENGTH_WIDTH-1:0] pos);
        string                 w;
        logic [KIND_WIDTH-1:0] kd;
        int                    k;
        for (k = 0; k < KEYWORD_COUNT; k++) begin
            keyword_at(k, w, kd);
            if (kw_live[k] && (int'(pos) >= w.len() || w[int'(pos)] != c))
                kw_live[k] = 1'b0;
        end
    endfunction

    function automatic void close_open_token();
        logic [KIND_WIDTH-1:0] kind;
        logic [KIND_WIDTH-1:0] kd;
        string                 w;
        int                    k;
        case (lex_mode)
            LEX_WORD: begin
                kind = TK_IDENT;
                // Walk downward so that the lowest matching table entry wins.
                for (k = KEYWORD_COUNT - 1; k >= 0; k--) begin
                    keyword_at(k, w, kd);
                    if (kw_live[k] && w.len() == int'(tok_len))
                        kind = kd;
                end
                push_token(kind, tok_start, tok_len);
            end
            LEX_NUM: begin
                kind = num_bad ? TK_ILLEGAL : (dot_seen ? TK_FLOAT : TK_INT);
                push_token(kind, tok_start, tok_len);
            end
            LEX_OP: begin
                case (op_held)
                    OP_ASSIGN: kind = TK_ASSIGN;
                    OP_LT:     kind = TK_LT;
                    OP_GT:     kind = TK_GT;
                    default:   kind = TK_NOT;
                endcase
                push_token(kind, tok_start, LEN_ONE);
            end
            default: ;
        endcase
        lex_mode = LEX_IDLE;
    endfunction

    function automatic void begin_lexeme(input logic [7:0] c);
        tok_start = byte_pos;
        case (c)
            CH_SPACE, CH_TAB, CH_CR: ;
            CH_LF: if (line_no != '1) line_no++;
            CH_EQUAL: begin op_held = OP_ASSIGN; lex_mode = LEX_OP; end
            "<":      begin op_held = OP_LT;     lex_mode = LEX_OP; end
            ">":      begin op_held = OP_GT;     lex_mode = LEX_OP; end
            "!":      begin op_held = OP_NOT;    lex_mode = LEX_OP; end
            ";": push_token(TK_SEMI, tok_start, LEN_ONE);
            "(": push_token(TK_LPAREN, tok_start, LEN_ONE);
            ")": push_token(TK_RPAREN, tok_start, LEN_ONE);
            "{": push_token(TK_LBRACE, tok_start, LEN_ONE);
            "}": push_token(TK_RBRACE, tok_start, LEN_ONE);
            "[": push_token(TK_LBRACK, tok_start, LEN_ONE);
            "]": push_token(TK_RBRACK, tok_start, LEN_ONE);
            ",": push_token(TK_COMMA, tok_start, LEN_ONE);
            "+": push_token(TK_PLUS, tok_start, LEN_ONE);
            "*": push_token(TK_STAR, tok_start, LEN_ONE);
            "/": push_token(TK_SLASH, tok_start, LEN_ONE);
            "-": push_token(TK_MINUS, tok_start, LEN_ONE);
            default: begin
                if (letter_byte(c)) begin
                    lex_mode = LEX_WORD;
                    kw_live  = '1;
                    narrow_keywords(c, '0);
                    tok_len  = LEN_ONE;
                end else if (digit_byte(c)) begin
                    lex_mode = LEX_NUM;
                    dot_seen = 1'b0;
                    num_bad  = 1'b0;
                    tok_len  = LEN_ONE;
                end else begin
                    push_token(TK_ILLEGAL, tok_start, LEN_ONE);
                end
            end
        endcase
    endfunction

    function automatic void lex_byte(input logic [7:0] c, input logic fin);
        logic [KIND_WIDTH-1:0] kind;
        t_token                t;
        int                    first;
        first = expected_tokens.size();
        if (lex_mode == LEX_DONE)
            return;
        if (fin || c == CH_NUL) begin
            close_open_token();
            push_token(TK_EOF, byte_pos, '0);
            lex_mode = LEX_DONE;
        end else if (lex_mode == LEX_OP && c == CH_EQUAL) begin
            case (op_held)
                OP_ASSIGN: kind = TK_EQ;
                OP_LT:     kind = TK_LE;
                OP_GT:     kind = TK_GE;
                default:   kind = TK_NE;
            endcase
            push_token(kind, tok_start, LEN_TWO);
            lex_mode = LEX_IDLE;
        end else if (lex_mode == LEX_WORD &&
                     (letter_byte(c) || digit_byte(c) || c == CH_UNDER)) begin
            narrow_keywords(c, tok_len);
            if (tok_len != '1) tok_len++;
        end else if (lex_mode == LEX_NUM && (digit_byte(c) || c == CH_DOT)) begin
            if (c == CH_DOT) begin
                if (dot_seen) num_bad = 1'b1;
                dot_seen = 1'b1;
            end
            if (tok_len != '1) tok_len++;
        end else begin
            // The byte that ends an open token starts the next one.
            close_open_token();
            begin_lexeme(c);
        end
        if (byte_pos != '1) byte_pos++;
        if (expected_tokens.size() > first) begin
            t = expected_tokens[expected_tokens.size() - 1];
            t.last = 1'b1;
            expected_tokens[expected_tokens.size() - 1] = t;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lex_mode  = LEX_IDLE;
            op_held   = OP_ASSIGN;
            tok_start = '0;
            tok_len   = '0;
            dot_seen  = 1'b0;
            num_bad   = 1'b0;
            kw_live   = '0;
            byte_pos  = '0;
            line_no   = LINE_WIDTH'(1);
            expected_tokens.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                lex_byte(i_char_in, i_is_end);
            if (i_out_valid && i_out_ready) begin
                if (expected_tokens.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected token kind %0d start %0d length %0d line %0d",
                             $time, i_token_kind, i_start_offset, i_token_length,
                             i_line_number);
                end else begin
                    want = expected_tokens.pop_front();
                    if (i_token_kind !== want.kind || i_start_offset !== want.start ||
                        i_token_length !== want.len || i_line_number !== want.line ||
                        i_last_of_run !== want.last) begin
                        fail_count++;
                        $display({"%0t: token mismatch, expected kind %0d start %0d ",
                                  "length %0d line %0d last %0b, got kind %0d start %0d ",
                                  "length %0d line %0d last %0b"},
                                 $time, want.kind, want.start, want.len, want.line,
                                 want.last, i_token_kind, i_start_offset, i_token_length,
                                 i_line_number, i_last_of_run);
                    end
                end
            end
        end
        o_pending <= expected_tokens.size();
    end

endmodule

[dv/tb_source_text_tokenizer_core.sv]
`timescale 1ns / 1ps

module tb_source_text_tokenizer_core;

    import stt_pkg::*;

    localparam int IDLE_LIMIT   = 500;
    localparam int SETTLE_TICKS = 16;
    localparam int RANDOM_BYTES = 2000;
    localparam int LONG_RUN     = 40;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [7:0]              i_char_in;
    logic                    i_is_end;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [KIND_WIDTH-1:0]   o_token_kind;
    logic [OFFSET_WIDTH-1:0] o_start_offset;
    logic [LENGTH_WIDTH-1:0] o_token_length;
    logic [LINE_WIDTH-1:0]   o_line_number;
    logic                    o_last_of_run;

    int pending_tokens;
    int checker_fails;
    bit steady = 1'b0;
    int bytes_sent = 0;

    source_text_tokenizer_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_in      (i_char_in),
        .i_is_end       (i_is_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_token_kind   (o_token_kind),
        .o_start_offset (o_start_offset),
        .o_token_length (o_token_length),
        .o_line_number  (o_line_number),
        .o_last_of_run  (o_last_of_run)
    );

    source_text_tokenizer_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_char_in      (i_char_in),
        .i_is_end       (i_is_end),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_token_kind   (o_token_kind),
        .i_start_offset (o_start_offset),
        .i_token_length (o_token_length),
        .i_line_number  (o_line_number),
        .i_last_of_run  (o_last_of_run),
        .o_pending      (pending_tokens),
        .o_fail_count   (checker_fails)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    task automatic send_byte(input logic [7:0] c, input logic fin);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_in  <= c;
        i_is_end   <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    // Holds the input side off until every predicted token has come out.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_tokens != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [7:0] word_char(input bit lead);
        int r;
        r = $urandom_range(0, lead ? 1 : 3);
        case (r)
            0:       return 8'("a" + $urandom_range(0, 25));
            1:       return 8'("A" + $urandom_range(0, 25));
            2:       return 8'("0" + $urandom_range(0, 9));
            default: return CH_UNDER;
        endcase
    endfunction

    function automatic string pick_keyword();
        case ($urandom_range(0, 17))
            0:       return "function";
            1:       return "define";
            2:       return "return";
            3:       return "let";
            4:       return "henceforth";
            5:       return "int";
            6:       return "float";
            7:       return "byte";
            8:       return "bool";
            9:       return "void";
            10:      return "string";
            11:      return "if";
            12:      return "else";
            13:      return "while";
            14:      return "for";
            15:      return "true";
            16:      return "false";
            default: return "entry";
        endcase
    endfunction

    task automatic send_lexeme();
        string punct;
        string blank;
        string w;
        int    pick;
        int    n;
        punct = ";(){}[],+*/-";
        blank = " \t\r\n";
        pick  = $urandom_range(0, 99);
        if (pick < 20) begin
            send_byte(word_char(1'b1), 1'b0);
            repeat ($urandom_range(0, 10)) send_byte(word_char(1'b0), 1'b0);
        end else if (pick < 36) begin
            // Exact keywords, and near misses that must stay identifiers.
            w = pick_keyword();
            case ($urandom_range(0, 3))
                0: ;
                1: if (w.len() > 1) w = w.substr(0, w.len() - 2);
                2: w = {w, string'(word_char(1'b0))};
                default: w[0] = w[0] - 8'd32;
            endcase
            send_text(w);
        end else if (pick < 50) begin
            send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
            n = $urandom_range(0, 7);
            repeat (n) begin
                if ($urandom_range(0, 4) == 0)
                    send_byte(CH_DOT, 1'b0);
                else
                    send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
            end
        end else if (pick < 62) begin
            w = "=<>!";
            send_byte(w[$urandom_range(0, 3)], 1'b0);
            if ($urandom_range(0, 1) == 1)
                send_byte(CH_EQUAL, 1'b0);
        end else if (pick < 74) begin
            send_byte(punct[$urandom_range(0, punct.len() - 1)], 1'b0);
        end else if (pick < 88) begin
            send_byte(blank[$urandom_range(0, 3)], 1'b0);
        end else if (pick < 95) begin
            send_byte(8'($urandom_range(1, 255)), 1'b0);
        end else begin
            send_byte($urandom_range(0, 1) ? CH_DOT : CH_UNDER, 1'b0);
        end
    endtask

    initial begin
        int stall;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_source_text_tokenizer_core NOT OK");
        $finish;
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_char_in  <= CH_NUL;
        i_is_end   <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Paired operators, a float, a malformed number, a lone dot and high bytes.
        send_text("if(x<=3.5)a_!=1..2;\n.\t");
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        wait_drained();

        while (bytes_sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 39) == 0)
                steady = ($urandom_range(0, 3) == 0);
            send_lexeme();
            if ($urandom_range(0, 2) == 0)
                send_byte(CH_SPACE, 1'b0);
            if ($urandom_range(0, 299) == 0)
                wait_drained();
        end
        wait_drained();

        // A long identifier, a long float and a run of blank lines, back to back.
        steady = 1'b1;
        send_text("function");
        repeat (LONG_RUN) send_byte(word_char(1'b0), 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte("7", 1'b0);
        repeat (LONG_RUN / 2) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
        send_byte(CH_DOT, 1'b0);
        repeat (LONG_RUN / 2) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
        send_byte(";", 1'b0);
        repeat (LONG_RUN) send_byte(CH_LF, 1'b0);
        steady = 1'b0;
        repeat (30) send_lexeme();

        // End of input closes an open token first.
        if ($urandom_range(0, 1) == 1)
            send_byte("<", 1'b0);
        else
            send_text("ab");
        if ($urandom_range(0, 1) == 1)
            send_byte(CH_NUL, 1'b0);
        else
            send_byte(8'($urandom_range(0, 255)), 1'b1);

        // Everything after the end of input is dropped.
        send_byte(CH_NUL, 1'b1);
        send_byte("A", 1'b0);
        repeat (6) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        wait_drained();
        repeat (SETTLE_TICKS) @(posedge i_clk);

        if (checker_fails == 0)
            $display("tb_source_text_tokenizer_core OK");
        else
            $display("tb_source_text_tokenizer_core NOT OK");
        $finish;
    end

endmodule
